// ----- rtl/servo_response_deframer_macros.svh -----
// Assertion macros shared by the servo response deframer RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef SERVO_RESPONSE_DEFRAMER_MACROS_SVH
`define SERVO_RESPONSE_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define SRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/srd_pkg.sv -----
// Types, codes and constants of the servo response deframer.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package srd_pkg;

	localparam int unsigned TIMER_BITS_DEF = 16;
	localparam int unsigned TIMEOUT_W = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] MIN_LENGTH = 8'd2;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_HEADER = 3'd1;
	localparam logic [2:0] ST_HEADER_BAD = 3'd2;
	localparam logic [2:0] ST_NO_ID = 3'd3;
	localparam logic [2:0] ST_NO_LENGTH = 3'd4;
	localparam logic [2:0] ST_INCOMPLETE = 3'd5;
	localparam logic [2:0] ST_LENGTH_BAD = 3'd6;
	localparam logic [2:0] ST_CHECKSUM_BAD = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HDR1 = 3'd1,
		PH_HDR2 = 3'd2,
		PH_ID   = 3'd3,
		PH_LEN  = 3'd4,
		PH_BODY = 3'd5
	} phase_t;

	typedef struct packed {
		logic       has_result;
		logic       kind;
		logic [7:0] param_byte;
		logic [2:0] status;
		logic [7:0] unit_id;
		logic [7:0] servo_error;
		logic [7:0] param_count;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/srd_if.sv -----
// Handshake channels of the servo response deframer: input items, results
// and the configuration write port. Depends on srd_pkg for the configuration data width.
`default_nettype none

interface srd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface srd_rsp_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] param_byte;
	logic [2:0] status;
	logic [7:0] unit_id;
	logic [7:0] servo_error;
	logic [7:0] param_count;
	modport source (output valid, output kind, output param_byte, output status,
		output unit_id, output servo_error, output param_count, input ready);
	modport sink (input valid, input kind, input param_byte, input status,
		input unit_id, input servo_error, input param_count, output ready);
endinterface

interface srd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [srd_pkg::TIMEOUT_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/srd_core.sv -----
// Packet state machine of the servo response deframer: holds the packet
// state and works out the result of one item. Depends on srd_pkg.
`default_nettype none
`include "servo_response_deframer_macros.svh"

module srd_core #(
	parameter int unsigned TIMER_BITS = srd_pkg::TIMER_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            step,
	input  wire  [1:0]                     action,
	input  wire  [7:0]                     rx_byte,
	input  wire  [srd_pkg::TIMEOUT_W-1:0]  timeout,
	output srd_pkg::result_t               res
);

	localparam int unsigned CMP_W =
		(TIMER_BITS > srd_pkg::TIMEOUT_W) ? TIMER_BITS : srd_pkg::TIMEOUT_W;

	srd_pkg::phase_t phase_q, phase_n;
	logic                  first_ok_q, first_ok_n;
	logic [7:0]            id_q, id_n;
	logic [7:0]            len_q, len_n;
	logic [7:0]            taken_q, taken_n;
	logic [7:0]            sum_q, sum_n;
	logic [7:0]            err_q, err_n;
	logic [7:0]            params_q, params_n;
	logic [TIMER_BITS-1:0] tick_q, tick_n;
	logic [TIMER_BITS-1:0] tick_sat;
	logic [8:0]            taken_inc;
	logic [2:0]            timeout_status;

	function automatic srd_pkg::result_t done(input logic [2:0] status,
		input logic [7:0] id, input logic [7:0] err, input logic [7:0] count);
		srd_pkg::result_t r;
		r = '0;
		r.has_result = 1'b1;
		r.kind = srd_pkg::KIND_DONE;
		r.status = status;
		r.unit_id = id;
		r.servo_error = err;
		r.param_count = count;
		return r;
	endfunction

	assign tick_sat = (tick_q == {TIMER_BITS{1'b1}}) ? tick_q : tick_q + 1'b1;
	assign taken_inc = {1'b0, taken_q} + 9'd1;

	always_comb begin
		unique case (phase_q)
			srd_pkg::PH_ID:   timeout_status = srd_pkg::ST_NO_ID;
			srd_pkg::PH_LEN:  timeout_status = srd_pkg::ST_NO_LENGTH;
			srd_pkg::PH_BODY: timeout_status = srd_pkg::ST_INCOMPLETE;
			default:          timeout_status = srd_pkg::ST_NO_HEADER;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		first_ok_n = first_ok_q;
		id_n = id_q;
		len_n = len_q;
		taken_n = taken_q;
		sum_n = sum_q;
		err_n = err_q;
		params_n = params_q;
		tick_n = tick_q;
		res = '0;
		if (step) begin
			unique case (action)
				srd_pkg::ACT_START: begin
					phase_n = srd_pkg::PH_HDR1;
					first_ok_n = 1'b0;
					id_n = '0;
					len_n = '0;
					taken_n = '0;
					sum_n = '0;
					err_n = '0;
					params_n = '0;
					tick_n = '0;
				end
				srd_pkg::ACT_BYTE: begin
					unique case (phase_q)
						srd_pkg::PH_IDLE: begin
						end
						srd_pkg::PH_HDR1: begin
							first_ok_n = (rx_byte == srd_pkg::HEADER_BYTE);
							phase_n = srd_pkg::PH_HDR2;
						end
						srd_pkg::PH_HDR2: begin
							if (!first_ok_q || rx_byte != srd_pkg::HEADER_BYTE) begin
								res = done(srd_pkg::ST_HEADER_BAD, id_q, err_q, params_q);
								phase_n = srd_pkg::PH_IDLE;
							end else begin
								phase_n = srd_pkg::PH_ID;
								tick_n = '0;
							end
						end
						srd_pkg::PH_ID: begin
							id_n = rx_byte;
							sum_n = rx_byte;
							phase_n = srd_pkg::PH_LEN;
							tick_n = '0;
						end
						srd_pkg::PH_LEN: begin
							len_n = rx_byte;
							sum_n = sum_q + rx_byte;
							if (rx_byte < srd_pkg::MIN_LENGTH) begin
								res = done(srd_pkg::ST_LENGTH_BAD, id_q, err_q, params_q);
								phase_n = srd_pkg::PH_IDLE;
							end else begin
								phase_n = srd_pkg::PH_BODY;
								taken_n = '0;
								tick_n = '0;
							end
						end
						srd_pkg::PH_BODY: begin
							if (taken_inc >= {1'b0, len_q}) begin
								res = done((~sum_q == rx_byte) ? srd_pkg::ST_OK
									: srd_pkg::ST_CHECKSUM_BAD, id_q, err_q, params_q);
								phase_n = srd_pkg::PH_IDLE;
							end else begin
								sum_n = sum_q + rx_byte;
								taken_n = taken_inc[7:0];
								if (taken_q == '0) begin
									err_n = rx_byte;
								end else begin
									params_n = params_q + 8'd1;
									res.has_result = 1'b1;
									res.kind = srd_pkg::KIND_PARAM;
									res.param_byte = rx_byte;
								end
							end
						end
						default: begin
							phase_n = srd_pkg::PH_IDLE;
						end
					endcase
				end
				srd_pkg::ACT_TICK: begin
					if (phase_q != srd_pkg::PH_IDLE) begin
						tick_n = tick_sat;
						if (CMP_W'(tick_sat) >= CMP_W'(timeout)) begin
							res = done(timeout_status, id_q, err_q, params_q);
							phase_n = srd_pkg::PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srd_pkg::PH_IDLE;
			first_ok_q <= 1'b0;
			id_q <= '0;
			len_q <= '0;
			taken_q <= '0;
			sum_q <= '0;
			err_q <= '0;
			params_q <= '0;
			tick_q <= '0;
		end else begin
			phase_q <= phase_n;
			first_ok_q <= first_ok_n;
			id_q <= id_n;
			len_q <= len_n;
			taken_q <= taken_n;
			sum_q <= sum_n;
			err_q <= err_n;
			params_q <= params_n;
			tick_q <= tick_n;
		end
	end

	`SRD_ASSERT_IMPLY(a_idle_silent, clk, arst_n,
		step && phase_q == srd_pkg::PH_IDLE && action != srd_pkg::ACT_START,
		!res.has_result)
	`SRD_ASSERT_IMPLY(a_param_in_body, clk, arst_n,
		res.has_result && res.kind == srd_pkg::KIND_PARAM,
		phase_q == srd_pkg::PH_BODY && taken_q != '0)
	`SRD_ASSERT_NEXT(a_done_to_idle, clk, arst_n,
		res.has_result && res.kind == srd_pkg::KIND_DONE,
		phase_q == srd_pkg::PH_IDLE)

endmodule

`default_nettype wire

// ----- rtl/servo_response_deframer.sv -----
// Servo response deframer: takes one input item per clock cycle while the output
// register is free or being emptied, a start, a received byte or a time tick, and
// gives each parameter byte of a servo status packet as it arrives followed by one
// result with status, id, error byte and parameter count. Each item waits in the
// input register until the output register is free or being emptied; its result,
// if any, is then registered in the output register. The packet state is updated
// in that single pass. The timeout resets to 100 and the user must write it
// through the configuration channel only while no packet is busy; the block itself
// does not enforce this. Depends on srd_pkg, the channel interfaces and srd_core.
`default_nettype none
`include "servo_response_deframer_macros.svh"

module servo_response_deframer #(
	parameter int unsigned TIMER_BITS = srd_pkg::TIMER_BITS_DEF
) (
	input wire        clk,
	input wire        arst_n,
	srd_req_if.sink   req,
	srd_rsp_if.source rsp,
	srd_cfg_if.sink   cfg
);

	logic                          valid_s1;
	logic [1:0]                    action_s1;
	logic [7:0]                    byte_s1;
	logic                          valid_s2;
	srd_pkg::result_t              res_s2;
	logic [srd_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                          advance;
	srd_pkg::result_t              res;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= srd_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1 <= req.action;
			byte_s1 <= req.rx_byte;
		end
	end

	srd_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.action(action_s1),
		.rx_byte(byte_s1),
		.timeout(timeout_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.has_result;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.kind = res_s2.kind;
	assign rsp.param_byte = res_s2.param_byte;
	assign rsp.status = res_s2.status;
	assign rsp.unit_id = res_s2.unit_id;
	assign rsp.servo_error = res_s2.servo_error;
	assign rsp.param_count = res_s2.param_count;

	`SRD_ASSERT_NEXT(a_item_captured, clk, arst_n, req.valid && req.ready, valid_s1)
	`SRD_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance && res.has_result, valid_s2)
	`SRD_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, valid_s2 && !rsp.ready, !advance)

endmodule

`default_nettype wire

// ----- verif/tb_servo_response_deframer.sv -----
// Testbench for servo_response_deframer: drives starts, received bytes and ticks;
// a behavioral parser model predicts each parameter and status beat a directed row lacks.
// Depends on srd_pkg, the srd channel interfaces and the servo_response_deframer RTL.
`default_nettype none

module tb_servo_response_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 4;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ITEMS_PER_SEG = 340;
	localparam int TIMER_BITS = srd_pkg::TIMER_BITS_DEF;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [1:0]       act;
		logic [7:0]       data;
		bit               typed;
		srd_pkg::result_t want;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n;

	srd_req_if req_ch ();
	srd_rsp_if rsp_ch ();
	srd_cfg_if cfg_ch ();

	servo_response_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	srd_pkg::phase_t       frame_phase = srd_pkg::PH_IDLE;
	bit                    header_ok;
	logic [7:0]            pkt_id;
	logic [7:0]            pkt_len;
	logic [7:0]            body_taken;
	logic [7:0]            check_sum;
	logic [7:0]            srv_err;
	logic [7:0]            params_sent;
	logic [TIMER_BITS-1:0] ticks;
	logic [15:0]           tick_limit = srd_pkg::TIMEOUT_RESET;

	srd_pkg::result_t pending_results[$];
	int      fail_count;
	int      work_items;
	int      cycle_count;
	int      send_idle_pct;
	int      recv_stall_pct;

	vector_t directed_rows [27] = '{
		'{srd_pkg::ACT_TICK, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h55, 1'b0, '0},
		'{ACT_NONE, 8'hAA, 1'b0, '0},
		'{srd_pkg::ACT_START, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b1,
			{1'b1, srd_pkg::KIND_DONE, 8'h00, srd_pkg::ST_HEADER_BAD, 8'h00, 8'h00, 8'h00}},
		'{srd_pkg::ACT_START, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFE, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h01, 1'b1,
			{1'b1, srd_pkg::KIND_DONE, 8'h00, srd_pkg::ST_LENGTH_BAD, 8'hFE, 8'h00, 8'h00}},
		'{srd_pkg::ACT_START, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h04, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h00, 1'b1,
			{1'b1, srd_pkg::KIND_PARAM, 8'h00, srd_pkg::ST_OK, 8'h00, 8'h00, 8'h00}},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b1,
			{1'b1, srd_pkg::KIND_PARAM, 8'hFF, srd_pkg::ST_OK, 8'h00, 8'h00, 8'h00}},
		'{srd_pkg::ACT_BYTE, 8'hFE, 1'b1,
			{1'b1, srd_pkg::KIND_DONE, 8'h00, srd_pkg::ST_OK, 8'hFF, 8'hFF, 8'h02}},
		'{srd_pkg::ACT_START, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h02, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
		'{srd_pkg::ACT_BYTE, 8'h00, 1'b1,
			{1'b1, srd_pkg::KIND_DONE, 8'h00, srd_pkg::ST_CHECKSUM_BAD, 8'h00, 8'h00, 8'h00}}
	};

	logic [15:0] seg_limits [6] = '{16'd1, 16'd6, 16'd65535, 16'd20, 16'd100, 16'd3};

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void queue_result(srd_pkg::result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic srd_pkg::result_t close_packet(logic [2:0] st);
		srd_pkg::result_t r;
		r = {1'b1, srd_pkg::KIND_DONE, 8'h00, st, pkt_id, srv_err, params_sent};
		frame_phase = srd_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic srd_pkg::result_t step_deframer(logic [1:0] act, logic [7:0] b);
		srd_pkg::result_t r;
		logic [2:0]       st;
		r = '0;
		case (act)
			srd_pkg::ACT_START: begin
				header_ok = 1'b0;
				pkt_id = '0;
				pkt_len = '0;
				body_taken = '0;
				check_sum = '0;
				srv_err = '0;
				params_sent = '0;
				ticks = '0;
				frame_phase = srd_pkg::PH_HDR1;
			end
			srd_pkg::ACT_BYTE: begin
				case (frame_phase)
					srd_pkg::PH_HDR1: begin
						header_ok = (b == srd_pkg::HEADER_BYTE);
						frame_phase = srd_pkg::PH_HDR2;
					end
					srd_pkg::PH_HDR2: begin
						if (!header_ok || b != srd_pkg::HEADER_BYTE) begin
							r = close_packet(srd_pkg::ST_HEADER_BAD);
						end else begin
							frame_phase = srd_pkg::PH_ID;
							ticks = '0;
						end
					end
					srd_pkg::PH_ID: begin
						pkt_id = b;
						check_sum = b;
						frame_phase = srd_pkg::PH_LEN;
						ticks = '0;
					end
					srd_pkg::PH_LEN: begin
						pkt_len = b;
						check_sum = check_sum + b;
						if (b < srd_pkg::MIN_LENGTH) begin
							r = close_packet(srd_pkg::ST_LENGTH_BAD);
						end else begin
							frame_phase = srd_pkg::PH_BODY;
							body_taken = '0;
							ticks = '0;
						end
					end
					srd_pkg::PH_BODY: begin
						if ({1'b0, body_taken} + 9'd1 >= {1'b0, pkt_len}) begin
							r = close_packet((~check_sum == b) ? srd_pkg::ST_OK
								: srd_pkg::ST_CHECKSUM_BAD);
						end else begin
							check_sum = check_sum + b;
							if (body_taken == 8'd0) begin
								srv_err = b;
								body_taken = 8'd1;
							end else begin
								body_taken = body_taken + 8'd1;
								params_sent = params_sent + 8'd1;
								r = {1'b1, srd_pkg::KIND_PARAM, b, srd_pkg::ST_OK,
									8'h00, 8'h00, 8'h00};
							end
						end
					end
					default: begin
					end
				endcase
			end
			srd_pkg::ACT_TICK: begin
				if (frame_phase != srd_pkg::PH_IDLE) begin
					if (ticks != '1)
						ticks = ticks + 1'b1;
					if (ticks >= tick_limit) begin
						case (frame_phase)
							srd_pkg::PH_HDR1, srd_pkg::PH_HDR2: st = srd_pkg::ST_NO_HEADER;
							srd_pkg::PH_ID: st = srd_pkg::ST_NO_ID;
							srd_pkg::PH_LEN: st = srd_pkg::ST_NO_LENGTH;
							default: st = srd_pkg::ST_INCOMPLETE;
						endcase
						r = close_packet(st);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		srd_pkg::result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: kind %0d status %0d",
					rsp_ch.kind, rsp_ch.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 8'(want.kind), 8'(rsp_ch.kind));
				check_field("param_byte", want.param_byte, rsp_ch.param_byte);
				check_field("status", 8'(want.status), 8'(rsp_ch.status));
				check_field("unit_id", want.unit_id, rsp_ch.unit_id);
				check_field("servo_error", want.servo_error, rsp_ch.servo_error);
				check_field("param_count", want.param_count, rsp_ch.param_count);
			end
		end
	end

	task automatic send_item(logic [1:0] act, logic [7:0] b, bit typed = 1'b0,
		srd_pkg::result_t typed_res = '0);
		srd_pkg::result_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.rx_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		if (act == srd_pkg::ACT_START || (frame_phase != srd_pkg::PH_IDLE
			&& (act == srd_pkg::ACT_BYTE || act == srd_pkg::ACT_TICK)))
			work_items++;
		got = step_deframer(act, b);
		if (typed)
			queue_result(typed_res);
		else if (got.has_result)
			queue_result(got);
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		tick_limit = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_packet(int len_pick);
		logic [7:0] frame[$];
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] pb;
		int         r;
		int         cut;
		int         i;
		frame = {};
		frame = {frame, (($urandom_range(99) < 4) ? 8'($urandom) : srd_pkg::HEADER_BYTE)};
		frame = {frame, (($urandom_range(99) < 4) ? 8'($urandom) : srd_pkg::HEADER_BYTE)};
		frame = {frame, 8'($urandom)};
		r = $urandom_range(99);
		if (len_pick >= 0)
			len = 8'(len_pick);
		else if (r < 72)
			len = 8'($urandom_range(12, 2));
		else if (r < 80)
			len = 8'($urandom_range(1, 0));
		else if (r < 98)
			len = 8'($urandom_range(60, 13));
		else
			len = 8'($urandom_range(255, 61));
		frame = {frame, len};
		sum = frame[2] + len;
		if (len >= srd_pkg::MIN_LENGTH) begin
			for (i = 1; i < len; i++) begin
				pb = 8'($urandom);
				frame = {frame, pb};
				sum = sum + pb;
			end
			pb = ~sum;
			if ($urandom_range(99) < 12)
				pb = pb ^ 8'($urandom_range(255, 1));
			frame = {frame, pb};
		end
		cut = ($urandom_range(99) < 5) ? $urandom_range(frame.size() - 1, 0) : frame.size();
		send_item(srd_pkg::ACT_START, 8'($urandom));
		for (i = 0; i < cut; i++) begin
			if (frame_phase == srd_pkg::PH_IDLE)
				break;
			r = $urandom_range(99);
			if (r < 12)
				repeat ($urandom_range(4, 1)) send_item(srd_pkg::ACT_TICK, 8'($urandom));
			else if (r < 14)
				repeat ($urandom_range((tick_limit > 300) ? 300 : tick_limit + 1, 1))
					send_item(srd_pkg::ACT_TICK, 8'($urandom));
			else if (r < 16)
				send_item(ACT_NONE, 8'($urandom));
			if (frame_phase == srd_pkg::PH_IDLE)
				break;
			send_item(srd_pkg::ACT_BYTE, frame[i]);
		end
	endtask

	initial begin : stimulus
		int seg;
		int goal;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = srd_pkg::ACT_START;
		req_ch.rx_byte = 8'h00;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		send_idle_pct = 18;
		recv_stall_pct = 61;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
				directed_rows[i].want);

		for (seg = 0; seg < 6; seg++) begin
			while (frame_phase != srd_pkg::PH_IDLE)
				send_item(srd_pkg::ACT_BYTE, 8'h00);
			settle();
			write_timeout(seg_limits[seg]);
			send_idle_pct = (seg / 2 == 0) ? 18 : (seg / 2 == 1) ? 61 : 0;
			recv_stall_pct = (seg / 2 == 0) ? 61 : (seg / 2 == 1) ? 18 : 0;
			if (seg == 2)
				send_packet(255);
			goal = work_items + ITEMS_PER_SEG;
			while (work_items < goal) begin
				if ($urandom_range(99) < 10)
					repeat ($urandom_range(3, 1))
						send_item(2'($urandom_range(3, 0)), 8'($urandom));
				send_packet(-1);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
